FILE: src/stwm_pkg.sv
// Shared types, codes and constants for the sorted entry table.
`default_nettype none
package stwm_pkg;
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int TAG_W           = 16;
   localparam int STAMP_W         = 32;
   localparam int SIZE_W          = 24;
   localparam int LIMIT_W         = 29;
   localparam int TOTAL_W         = 29;
   localparam int STATUS_W        = 2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 29'd8388608;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 29'h1FFFFFFF;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FITS     = 2'd3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TRIM   = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
      logic [SIZE_W-1:0]  size;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_op_type;
endpackage
`default_nettype wire

FILE: src/stwm_cell.sv
// One table slot: holds an entry and shifts it to or from its neighbors.
`default_nettype none
module stwm_cell (
   input  wire                   clock,
   input  stwm_pkg::cell_op_type op,
   input  stwm_pkg::entry_type   new_entry,
   input  stwm_pkg::entry_type   left_entry,
   input  stwm_pkg::entry_type   right_entry,
   output stwm_pkg::entry_type   entry_q,
   output logic                  stamp_lt
);
   import stwm_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      case (op)
         CELL_LOAD:       entry_in = new_entry;
         CELL_FROM_LEFT:  entry_in = left_entry;
         CELL_FROM_RIGHT: entry_in = right_entry;
         default:         entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // stored entry is older than the incoming one
   assign stamp_lt = entry_ff.stamp < new_entry.stamp;
   assign entry_q  = entry_ff;
endmodule
`default_nettype wire

FILE: src/sorted_table_with_min_size_trim_core.sv
// Top level of the sorted entry table with smallest-first trim.
// Usage:
//   req_* carries one item: an insert (opcode 0) or a trim (opcode 1).
//   rsp_* returns results; rsp_last_result marks the final one of an item.
//   csr_* writes the capacity limit; it is always ready and should be
//   written only while the block is idle.
// Timing:
//   An insert is done in the accept cycle; its result shows in the next cycle.
//   Each trim removal scans the stored entries one per cycle through a
//   shared index, then shifts the row of cells left in one step; up to 16
//   removals are made per trim item.
//   A trim that already fits answers in the cycle after accept.
//   One item is worked at a time; req_ready is high only when idle with no
//   result pending.
// Reset clears the fill count and total and sets the limit to 8388608;
// slot contents are not cleared. A stalled receiver holds the result
// register and the whole block until the result is taken.
`default_nettype none
module sorted_table_with_min_size_trim_core #(
   parameter int TABLE_DEPTH = stwm_pkg::TABLE_DEPTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_opcode,
   input  wire  [stwm_pkg::TAG_W-1:0]        req_entry_tag,
   input  wire  [stwm_pkg::STAMP_W-1:0]      req_entry_stamp,
   input  wire  [stwm_pkg::SIZE_W-1:0]       req_entry_size,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [stwm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [stwm_pkg::TAG_W-1:0]        rsp_removed_tag,
   output logic [stwm_pkg::STAMP_W-1:0]      rsp_removed_stamp,
   output logic [stwm_pkg::SIZE_W-1:0]       rsp_removed_size,
   output logic [stwm_pkg::TOTAL_W-1:0]      rsp_total_after,
   output logic                              rsp_last_result,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [stwm_pkg::LIMIT_W-1:0]      csr_capacity_limit
);
   import stwm_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int TOT_W  = SIZE_W + CNT_W;
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]  best_ff, best_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;
   logic [NRES_W-1:0]  nres_ff, nres_in;
   logic               cont_ff, cont_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   entry_type          rem_ff, rem_in;
   logic [TOTAL_W-1:0] tot_out_ff, tot_out_in;
   logic               last_ff, last_in;

   entry_type          new_entry;
   entry_type          cell_q   [TABLE_DEPTH];
   entry_type          right_q  [TABLE_DEPTH];
   entry_type          left_q   [TABLE_DEPTH];
   cell_op_type        cell_op  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] lt, ge, ge_prev;
   logic               insert_go, remove_go;
   entry_type          scan_entry, sel_entry;
   logic [TOT_W-1:0]   total_dec;
   logic [CNT_W-1:0]   fill_dec;

   assign new_entry = '{tag: req_entry_tag, stamp: req_entry_stamp, size: req_entry_size};

   // row of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == TABLE_DEPTH - 1) begin : g_r_end
         assign right_q[i] = cell_q[i];
      end else begin : g_r_mid
         assign right_q[i] = cell_q[i+1];
      end
      if (i == 0) begin : g_l_end
         assign left_q[i] = new_entry;
      end else begin : g_l_mid
         assign left_q[i] = cell_q[i-1];
      end
      // cell at or past the insert point
      assign ge[i] = !(lt[i] && (CNT_W'(i) < fill_ff));
      stwm_cell u_cell (
         .clock       (clock),
         .op          (cell_op[i]),
         .new_entry   (new_entry),
         .left_entry  (left_q[i]),
         .right_entry (right_q[i]),
         .entry_q     (cell_q[i]),
         .stamp_lt    (lt[i])
      );
   end

   assign ge_prev = {ge[TABLE_DEPTH-2:0], 1'b0};

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_op[i] = CELL_HOLD;
         if (insert_go) begin
            if (ge[i] && !ge_prev[i]) cell_op[i] = CELL_LOAD;
            else if (ge_prev[i])      cell_op[i] = CELL_FROM_LEFT;
         end else if (remove_go) begin
            if (ADDR_W'(i) >= best_ff) cell_op[i] = CELL_FROM_RIGHT;
         end
      end
   end

   assign scan_entry = cell_q[idx_ff[ADDR_W-1:0]];
   assign sel_entry  = cell_q[best_ff];
   assign total_dec  = total_ff - TOT_W'(sel_entry.size);
   assign fill_dec   = fill_ff - CNT_W'(1);

   function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOT_W-1:0] t);
      sat_total = (64'(t) > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(t);
   endfunction

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_size_in = best_size_ff;
      nres_in      = nres_ff;
      cont_in      = cont_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rem_in       = rem_ff;
      tot_out_in   = tot_out_ff;
      last_in      = last_ff;
      insert_go    = 1'b0;
      remove_go    = 1'b0;

      if (csr_valid) limit_in = csr_capacity_limit;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rem_in       = '0;
               last_in      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
               cont_in      = 1'b0;
               if (req_opcode == OP_INSERT) begin
                  if (fill_ff >= CNT_W'(TABLE_DEPTH)) begin
                     status_in  = ST_FULL;
                     tot_out_in = sat_total(total_ff);
                  end else begin
                     insert_go  = 1'b1;
                     fill_in    = fill_ff + CNT_W'(1);
                     total_in   = total_ff + TOT_W'(req_entry_size);
                     status_in  = ST_INSERTED;
                     tot_out_in = sat_total(total_ff + TOT_W'(req_entry_size));
                  end
               end else if (fill_ff != '0 && 64'(total_ff) > 64'(limit_ff)) begin
                  // start the first removal scan
                  rsp_valid_in = 1'b0;
                  state_in     = S_SCAN;
                  nres_in      = '0;
                  idx_in       = CNT_W'(1);
                  best_in      = '0;
                  best_size_in = cell_q[0].size;
               end else begin
                  status_in  = ST_FITS;
                  tot_out_in = sat_total(total_ff);
               end
            end
         end
         S_SCAN: begin
            if (idx_ff < fill_ff) begin
               if (scan_entry.size < best_size_ff) begin
                  best_in      = idx_ff[ADDR_W-1:0];
                  best_size_in = scan_entry.size;
               end
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               // drop the smallest entry, close the gap
               remove_go    = 1'b1;
               fill_in      = fill_dec;
               total_in     = total_dec;
               nres_in      = nres_ff + NRES_W'(1);
               status_in    = ST_REMOVED;
               rem_in       = sel_entry;
               tot_out_in   = sat_total(total_dec);
               last_in      = (nres_ff + NRES_W'(1) >= NRES_W'(MAX_RESULTS)) ||
                              (fill_dec == '0) || (64'(total_dec) <= 64'(limit_ff));
               cont_in      = !last_in;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (cont_ff) begin
                  state_in     = S_SCAN;
                  idx_in       = CNT_W'(1);
                  best_in      = '0;
                  best_size_in = cell_q[0].size;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         total_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         cont_ff      <= 1'b0;
         nres_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         cont_ff      <= cont_in;
         nres_ff      <= nres_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_size_ff <= best_size_in;
      status_ff    <= status_in;
      rem_ff       <= rem_in;
      tot_out_ff   <= tot_out_in;
      last_ff      <= last_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_tag   = rem_ff.tag;
   assign rsp_removed_stamp = rem_ff.stamp;
   assign rsp_removed_size  = rem_ff.size;
   assign rsp_total_after   = tot_out_ff;
   assign rsp_last_result   = last_ff;
endmodule
`default_nettype wire

FILE: src/stwm_checker.sv
// Port-level checks for the sorted entry table, bound to the top level.
`default_nettype none
module stwm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_status,
   input wire [15:0] rsp_removed_tag,
   input wire [31:0] rsp_removed_stamp,
   input wire [23:0] rsp_removed_size,
   input wire        rsp_last_result
);
   import stwm_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("item accepted while result pending");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_REMOVED |-> rsp_last_result)
      else $error("single result not marked last");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_REMOVED |->
         rsp_removed_tag == '0 && rsp_removed_stamp == '0 && rsp_removed_size == '0)
      else $error("removed fields not zero");
endmodule

bind sorted_table_with_min_size_trim_core stwm_checker u_stwm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_removed_tag   (rsp_removed_tag),
   .rsp_removed_stamp (rsp_removed_stamp),
   .rsp_removed_size  (rsp_removed_size),
   .rsp_last_result   (rsp_last_result)
);
`default_nettype wire
